// ===== rtl/pls_pkg.sv =====
package pls_pkg;

  localparam int unsigned DEPTH = 32;
  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned ACT_W = 3;
  localparam int unsigned POS_W = 6;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned STS_W = 3;
  localparam int unsigned CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  typedef enum logic [ACT_W-1:0] {
    ACT_DUMP    = 3'd0,
    ACT_INSERT  = 3'd1,
    ACT_DELETE  = 3'd2,
    ACT_SEARCH  = 3'd3,
    ACT_MAX     = 3'd4,
    ACT_MIN     = 3'd5,
    ACT_REVERSE = 3'd6
  } action_e;

  typedef enum logic [STS_W-1:0] {
    ST_OK        = 3'd0,
    ST_BAD_POS   = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_FULL      = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MOVE,
    S_FIN,
    S_SCAN,
    S_DUMP_RD,
    S_DUMP_WAIT,
    S_REV_RD_LO,
    S_REV_RD_HI,
    S_REV_WR_LO,
    S_REV_WR_HI,
    S_RESP
  } state_e;

  typedef struct packed {
    action_e                  action;
    logic [POS_W-1:0]         position;
    logic signed [VAL_W-1:0]  item_value;
  } in_item_t;

  typedef struct packed {
    status_e                  status;
    logic signed [VAL_W-1:0]  result_value;
    logic [POS_W-1:0]         found_position;
    logic                     last;
  } out_item_t;

  typedef struct packed {
    logic      valid;
    out_item_t item;
  } push_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [VAL_W-1:0] wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } ram_req_t;

endpackage

// ===== rtl/positional_list_store.sv =====
// Ordered list of signed 32-bit entries held in a single-port-pair RAM, plus an entry count.
// Each input item on the in channel names one action with a 1-based position and a value.
// Every action returns one result item on the out channel, except dump, which returns one
// item per stored entry (or a single empty-status item), and the unused action code, which
// returns nothing. The last field marks the final result item of an input item.
// The block works on one item at a time; in_ready_o is high only while it is idle.
// With n the number of entries, search, maximum and minimum read the n entries in order (no
// read on an empty list); insert and delete shift the entries after the insert or delete
// point by one place, reading one entry while writing the one read before; reverse reads and
// then writes each pair of entries from both ends inward; dump reads and returns each entry.
// A one-entry output register holds the result item; the block waits in place while the
// receiver holds out_ready_i low and continues as soon as the register drains.
// Reset empties the list and clears the output register; RAM contents are not cleared.
module positional_list_store (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  pls_pkg::in_item_t   in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output pls_pkg::out_item_t  out_item_o
);
  import pls_pkg::*;

  push_t            push;
  logic             push_ready;
  ram_req_t         ram_req;
  logic [VAL_W-1:0] ram_rdata;
  logic [CNT_W-1:0] count;

  pls_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_item_i    (in_item_i),
    .push_o       (push),
    .push_ready_i (push_ready),
    .ram_req_o    (ram_req),
    .ram_rdata_i  (ram_rdata),
    .count_o      (count)
  );

  pls_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .re_i    (ram_req.re),
    .raddr_i (ram_req.raddr),
    .rdata_o (ram_rdata)
  );

  pls_out_reg u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_item_o   (out_item_o)
  );

  a_push_has_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.valid |-> push_ready)
    else $error("Result item pushed while the output register is full.");

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count <= CNT_W'(DEPTH))
    else $error("Entry count exceeds the list depth.");

  a_idle_no_push : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !push.valid)
    else $error("Result item pushed while the sequencer is idle.");

  a_no_rw_same_entry : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_req.we && ram_req.re) |-> (ram_req.waddr != ram_req.raddr))
    else $error("RAM read and write hit the same entry in one cycle.");

endmodule

// ===== rtl/pls_ram.sv =====
module pls_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/pls_out_reg.sv =====
module pls_out_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pls_pkg::push_t      push_i,
  output logic                push_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output pls_pkg::out_item_t  out_item_o
);
  import pls_pkg::*;

  logic      valid_q, valid_d;
  out_item_t item_q;

  assign push_ready_o = !valid_q || out_ready_i;

  always_comb begin
    if (push_i.valid) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      item_q <= push_i.item;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

endmodule

// ===== rtl/pls_seq.sv =====
module pls_seq (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  pls_pkg::in_item_t            in_item_i,
  output pls_pkg::push_t               push_o,
  input  logic                         push_ready_i,
  output pls_pkg::ram_req_t            ram_req_o,
  input  logic [pls_pkg::VAL_W-1:0]    ram_rdata_i,
  output logic [pls_pkg::CNT_W-1:0]    count_o
);
  import pls_pkg::*;

  state_e                  state_q, state_d;
  logic [CNT_W-1:0]        count_q, count_d;
  logic                    pend_q, pend_d;
  action_e                 act_q, act_d;
  logic [POS_W-1:0]        pos_q, pos_d;
  logic [VAL_W-1:0]        val_q, val_d;
  logic [CNT_W-1:0]        ptr_q, ptr_d;
  logic [CNT_W-1:0]        rem_q, rem_d;
  logic [IDX_W-1:0]        dst_q, dst_d;
  logic [IDX_W-1:0]        pidx_q, pidx_d;
  logic                    found_q, found_d;
  logic [POS_W-1:0]        fpos_q, fpos_d;
  logic signed [VAL_W-1:0] best_q, best_d;
  logic [VAL_W-1:0]        tmp_q, tmp_d;
  logic [IDX_W-1:0]        lo_q, lo_d;
  logic [IDX_W-1:0]        hi_q, hi_d;
  out_item_t               res_q, res_d;

  logic [CMP_W-1:0]        n_cmp;
  logic [CMP_W-1:0]        pos_cmp;
  logic                    is_ins;

  assign n_cmp   = CMP_W'(count_q);
  assign pos_cmp = CMP_W'(in_item_i.position);
  assign is_ins  = (act_q == ACT_INSERT);

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    pend_d    = pend_q;
    act_d     = act_q;
    pos_d     = pos_q;
    val_d     = val_q;
    ptr_d     = ptr_q;
    rem_d     = rem_q;
    dst_d     = dst_q;
    pidx_d    = pidx_q;
    found_d   = found_q;
    fpos_d    = fpos_q;
    best_d    = best_q;
    tmp_d     = tmp_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    res_d     = res_q;
    ram_req_o = '0;
    push_o    = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          act_d  = in_item_i.action;
          pos_d  = in_item_i.position;
          val_d  = in_item_i.item_value;
          pend_d = 1'b0;
          ptr_d  = '0;
          res_d  = '{status: ST_OK, result_value: '0, found_position: '0, last: 1'b1};
          unique case (in_item_i.action)
            ACT_DUMP: begin
              if (count_q == '0) begin
                res_d.status = ST_EMPTY;
                state_d      = S_RESP;
              end else begin
                state_d = S_DUMP_RD;
              end
            end
            ACT_INSERT: begin
              if (count_q >= CNT_W'(DEPTH)) begin
                res_d.status = ST_FULL;
                state_d      = S_RESP;
              end else if (pos_cmp == '0 || pos_cmp > n_cmp + CMP_W'(1)) begin
                res_d.status = ST_BAD_POS;
                state_d      = S_RESP;
              end else begin
                rem_d   = CNT_W'(n_cmp - pos_cmp + CMP_W'(1));
                ptr_d   = count_q - CNT_W'(1);
                state_d = S_MOVE;
              end
            end
            ACT_DELETE: begin
              if (pos_cmp == '0 || pos_cmp > n_cmp) begin
                res_d.status = ST_BAD_POS;
                state_d      = S_RESP;
              end else begin
                rem_d   = CNT_W'(n_cmp - pos_cmp);
                ptr_d   = CNT_W'(pos_cmp);
                state_d = S_MOVE;
              end
            end
            ACT_SEARCH, ACT_MAX, ACT_MIN: begin
              found_d = 1'b0;
              fpos_d  = '0;
              if (count_q == '0) begin
                res_d.status = (in_item_i.action == ACT_SEARCH) ? ST_NOT_FOUND : ST_EMPTY;
                state_d      = S_RESP;
              end else begin
                state_d = S_SCAN;
              end
            end
            ACT_REVERSE: begin
              lo_d = '0;
              hi_d = IDX_W'(count_q - CNT_W'(1));
              if (count_q < CNT_W'(2)) begin
                state_d = S_RESP;
              end else begin
                state_d = S_REV_RD_LO;
              end
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end

      S_MOVE: begin
        if (pend_q) begin
          ram_req_o.we    = 1'b1;
          ram_req_o.waddr = dst_q;
          ram_req_o.wdata = ram_rdata_i;
        end
        if (rem_q != '0) begin
          ram_req_o.re    = 1'b1;
          ram_req_o.raddr = ptr_q[IDX_W-1:0];
          dst_d  = is_ins ? IDX_W'(ptr_q + CNT_W'(1)) : IDX_W'(ptr_q - CNT_W'(1));
          ptr_d  = is_ins ? ptr_q - CNT_W'(1) : ptr_q + CNT_W'(1);
          rem_d  = rem_q - CNT_W'(1);
          pend_d = 1'b1;
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            state_d = S_FIN;
          end
        end
      end

      S_FIN: begin
        if (is_ins) begin
          ram_req_o.we    = 1'b1;
          ram_req_o.waddr = IDX_W'(pos_q - POS_W'(1));
          ram_req_o.wdata = val_q;
          count_d         = count_q + CNT_W'(1);
        end else begin
          count_d = count_q - CNT_W'(1);
        end
        state_d = S_RESP;
      end

      S_SCAN: begin
        if (pend_q) begin
          if (act_q == ACT_SEARCH) begin
            if (!found_q && ram_rdata_i == val_q) begin
              found_d = 1'b1;
              fpos_d  = POS_W'(CMP_W'(pidx_q) + CMP_W'(1));
            end
          end else if (pidx_q == '0) begin
            best_d = $signed(ram_rdata_i);
          end else if (act_q == ACT_MAX) begin
            if ($signed(ram_rdata_i) > best_q) begin
              best_d = $signed(ram_rdata_i);
            end
          end else begin
            if ($signed(ram_rdata_i) < best_q) begin
              best_d = $signed(ram_rdata_i);
            end
          end
        end
        if (ptr_q < count_q) begin
          ram_req_o.re    = 1'b1;
          ram_req_o.raddr = ptr_q[IDX_W-1:0];
          pidx_d = ptr_q[IDX_W-1:0];
          ptr_d  = ptr_q + CNT_W'(1);
          pend_d = 1'b1;
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            if (act_q == ACT_SEARCH) begin
              res_d.status         = found_q ? ST_OK : ST_NOT_FOUND;
              res_d.found_position = fpos_q;
            end else begin
              res_d.result_value = best_q;
            end
            state_d = S_RESP;
          end
        end
      end

      S_DUMP_RD: begin
        ram_req_o.re    = 1'b1;
        ram_req_o.raddr = ptr_q[IDX_W-1:0];
        state_d         = S_DUMP_WAIT;
      end

      S_DUMP_WAIT: begin
        if (push_ready_i) begin
          push_o.valid               = 1'b1;
          push_o.item.status         = ST_OK;
          push_o.item.result_value   = $signed(ram_rdata_i);
          push_o.item.found_position = '0;
          push_o.item.last           = (ptr_q + CNT_W'(1) == count_q);
          ptr_d   = ptr_q + CNT_W'(1);
          state_d = (ptr_q + CNT_W'(1) == count_q) ? S_IDLE : S_DUMP_RD;
        end
      end

      S_REV_RD_LO: begin
        ram_req_o.re    = 1'b1;
        ram_req_o.raddr = lo_q;
        state_d         = S_REV_RD_HI;
      end

      S_REV_RD_HI: begin
        ram_req_o.re    = 1'b1;
        ram_req_o.raddr = hi_q;
        tmp_d           = ram_rdata_i;
        state_d         = S_REV_WR_LO;
      end

      S_REV_WR_LO: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = lo_q;
        ram_req_o.wdata = ram_rdata_i;
        state_d         = S_REV_WR_HI;
      end

      S_REV_WR_HI: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = hi_q;
        ram_req_o.wdata = tmp_q;
        lo_d            = lo_q + IDX_W'(1);
        hi_d            = hi_q - IDX_W'(1);
        if (CMP_W'(lo_q) + CMP_W'(2) < CMP_W'(hi_q)) begin
          state_d = S_REV_RD_LO;
        end else begin
          state_d = S_RESP;
        end
      end

      S_RESP: begin
        if (push_ready_i) begin
          push_o.valid = 1'b1;
          push_o.item  = res_q;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q   <= act_d;
    pos_q   <= pos_d;
    val_q   <= val_d;
    ptr_q   <= ptr_d;
    rem_q   <= rem_d;
    dst_q   <= dst_d;
    pidx_q  <= pidx_d;
    found_q <= found_d;
    fpos_q  <= fpos_d;
    best_q  <= best_d;
    tmp_q   <= tmp_d;
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    res_q   <= res_d;
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign count_o    = count_q;

endmodule
